/* src/gls_pkg.sv */
// gls_pkg: shared constants and the exp2 table entry function of the
// gaussian latent sampler. No dependencies; used by the top level and its checker.
package gls_pkg;

    localparam int DATA_W             = 32;
    localparam int DEF_FRAC_BITS      = 16;
    localparam int DEF_EXP_TABLE_BITS = 8;
    localparam int SCALE_FRAC         = 16;
    localparam logic [31:0] SCALE_RESET = 32'd65536;
    localparam logic [31:0] LOG2E_Q30   = 32'd1549082005;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // input accept to result strobe, in clock edges
    localparam int PIPE_LAT = 13;

    // 2^(i / 2^tbits) in Q30 by a series of exp(i * ln2 / 2^tbits), truncated after its 16th-order term
    function automatic logic [31:0] exp2_q30(input int unsigned i, input int unsigned tbits);
        logic [63:0] z;
        logic [63:0] sum;
        logic [63:0] term;
        z    = (64'(i) * LN2_Q30 + (64'd1 << (tbits - 1))) >> tbits;
        sum  = ONE_Q30;
        term = ONE_Q30;
        for (int k = 1; k <= 16; k++)
        begin
            term = ((term * z) >> 30) / 64'(k);
            sum  = sum + term;
        end
        return sum[31:0];
    endfunction

endpackage

/* src/gaussian_latent_sampler_unit.sv */
// gaussian_latent_sampler_unit: reparameterized gaussian sample, one element per item.
// Depends on gls_pkg; checked by gls_checker, bound from its own file.
//
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+---------------------------
//  input     | mean_value, log_variance, noise_value      | start && !busy
//  result    | latent_sample, saturated                   | done, one cycle, no stall
//  config    | cfg_wr_data                                | cfg_wr_en, no wait
//
//  An item may enter in every clock cycle; busy stays low.
//  Its result shows on done after 13 register stages, among them the log2e
//  multiply, exp2 rom read, interpolation multiply, noise multiply, shift, add,
//  and the 48x32 scale multiply split in two 24x32 partial products.
//  Reset clears the stage valid bits and loads the scale with 1.0.
//  The receiver cannot stall, so the pipeline never holds.
module gaussian_latent_sampler_unit #(
    parameter int FRAC_BITS      = gls_pkg::DEF_FRAC_BITS,
    parameter int EXP_TABLE_BITS = gls_pkg::DEF_EXP_TABLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [gls_pkg::DATA_W-1:0] mean_value,
    input  logic signed [gls_pkg::DATA_W-1:0] log_variance,
    input  logic signed [gls_pkg::DATA_W-1:0] noise_value,
    output logic                              done,
    output logic signed [gls_pkg::DATA_W-1:0] latent_sample,
    output logic                              saturated,
    input  logic                              cfg_wr_en,
    input  logic        [gls_pkg::DATA_W-1:0] cfg_wr_data
);
    import gls_pkg::*;

    localparam int LV_W      = FRAC_BITS + 6;
    localparam int LVP_W     = LV_W + 32;
    localparam int REM_W     = 32 - EXP_TABLE_BITS;
    localparam int DP_W      = 32 + REM_W;
    localparam int RA_W      = EXP_TABLE_BITS + 1;
    localparam int ROM_DEPTH = (1 << EXP_TABLE_BITS) + 1;
    localparam int SUM_W     = 48;
    localparam int HALF_W    = SUM_W / 2;

    localparam logic signed [31:0] LV_LO   = 32'(-30 * (2 ** FRAC_BITS));
    localparam logic signed [31:0] LV_HI   = 32'(20 * (2 ** FRAC_BITS));
    localparam logic signed [31:0] LOG2E_S = LOG2E_Q30;

    typedef logic [31:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            r[i] = exp2_q30(i, EXP_TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t EXP_ROM = build_rom();

    // control
    logic [PIPE_LAT-1:0] vld_reg;
    logic [31:0]         scale_reg;

    // stage registers
    logic signed [31:0]       mean1_reg, noise1_reg;
    logic signed [LV_W-1:0]   lv1_reg;
    logic signed [31:0]       mean2_reg, noise2_reg;
    logic signed [LVP_W-1:0]  lvp2_reg;
    logic signed [31:0]       mean3_reg, noise3_reg;
    logic signed [5:0]        n3_reg;
    logic [REM_W-1:0]         rem3_reg;
    logic [31:0]              e0_3_reg, e1_3_reg;
    logic signed [31:0]       mean4_reg, noise4_reg;
    logic signed [5:0]        n4_reg;
    logic [31:0]              e0_4_reg;
    logic [DP_W-1:0]          dp4_reg;
    logic signed [31:0]       mean5_reg, noise5_reg;
    logic signed [5:0]        n5_reg;
    logic [31:0]              m5_reg;
    logic signed [31:0]       mean6_reg;
    logic signed [5:0]        n6_reg;
    logic signed [63:0]       mn6_reg;
    logic signed [31:0]       mean7_reg;
    logic [5:0]               sh7_reg;
    logic                     neg7_reg;
    logic [62:0]              mag7_reg;
    logic signed [31:0]       mean8_reg;
    logic                     neg8_reg;
    logic [SUM_W-2:0]         shf8_reg;
    logic signed [SUM_W-1:0]  sum9_reg;
    logic                     neg10_reg;
    logic [SUM_W-1:0]         smag10_reg;
    logic                     neg11_reg;
    logic [HALF_W+31:0]       pl11_reg, ph11_reg;
    logic                     neg12_reg;
    logic [SUM_W+31:0]        full12_reg;
    logic signed [31:0]       res13_reg;
    logic                     sat13_reg;

    // next values
    logic signed [31:0]       lv_clamp;
    logic signed [LV_W-1:0]   lv1_next;
    logic signed [LVP_W-1:0]  lvp2_next;
    logic signed [LVP_W-1:0]  y_full;
    logic signed [LV_W-1:0]   y;
    logic [31:0]              f32;
    logic [RA_W-1:0]          ra0, ra1;
    logic [31:0]              diff;
    logic [DP_W-1:0]          dp4_next;
    logic [31:0]              m5_next;
    logic signed [63:0]       mn6_next;
    logic [5:0]               sh7_next;
    logic [62:0]              mag7_next;
    logic [SUM_W-2:0]         shf8_next;
    logic signed [SUM_W-1:0]  sum9_next;
    logic [SUM_W-1:0]         smag10_next;
    logic [HALF_W+31:0]       pl11_next, ph11_next;
    logic [SUM_W+31:0]        full12_next;
    logic [SUM_W-1:0]         prod;
    logic                     ovf;
    logic signed [31:0]       res13_next;
    logic                     sat13_next;

    assign busy = 1'b0;

    always_comb
    begin
        if (log_variance < LV_LO)
        begin
            lv_clamp = LV_LO;
        end
        else if (log_variance > LV_HI)
        begin
            lv_clamp = LV_HI;
        end
        else
        begin
            lv_clamp = log_variance;
        end
        lv1_next = LV_W'(lv_clamp);

        lvp2_next = LVP_W'(lv1_reg) * LVP_W'(LOG2E_S);

        // y = floor(lv * log2e / 2^31), n = floor(y), fraction in the low bits
        y_full = lvp2_reg >>> 31;
        y      = y_full[LV_W-1:0];
        f32    = {y[FRAC_BITS-1:0], {(32 - FRAC_BITS){1'b0}}};
        ra0    = {1'b0, f32[31:REM_W]};
        ra1    = ra0 + RA_W'(1);

        diff     = e1_3_reg - e0_3_reg;
        dp4_next = DP_W'(diff) * DP_W'(rem3_reg);

        m5_next = e0_4_reg + 32'(dp4_reg >> REM_W);

        mn6_next = 64'($signed({1'b0, m5_reg})) * 64'(noise5_reg);

        // shift right by 30 - n, truncating toward zero on the magnitude
        sh7_next  = 6'(7'd30 - 7'(n6_reg));
        mag7_next = mn6_reg[63] ? 63'(-mn6_reg) : mn6_reg[62:0];

        shf8_next = (SUM_W - 1)'(mag7_reg >> sh7_reg);

        sum9_next = neg8_reg ? (SUM_W'(mean8_reg) - SUM_W'(shf8_reg))
                             : (SUM_W'(mean8_reg) + SUM_W'(shf8_reg));

        smag10_next = sum9_reg[SUM_W-1] ? SUM_W'(-sum9_reg) : SUM_W'(sum9_reg);

        pl11_next = (HALF_W + 32)'(smag10_reg[HALF_W-1:0]) * (HALF_W + 32)'(scale_reg);
        ph11_next = (HALF_W + 32)'(smag10_reg[SUM_W-1:HALF_W]) * (HALF_W + 32)'(scale_reg);

        full12_next = ((SUM_W + 32)'(ph11_reg) << HALF_W) + (SUM_W + 32)'(pl11_reg);

        // product past 64 bits, or past the signed 32-bit range after the scale shift
        ovf  = |full12_reg[SUM_W+31:64];
        prod = full12_reg[63:SCALE_FRAC];
        if (ovf)
        begin
            sat13_next = 1'b1;
        end
        else if (!neg12_reg)
        begin
            sat13_next = |prod[SUM_W-1:31];
        end
        else
        begin
            sat13_next = (|prod[SUM_W-1:32]) || (prod[31] && (|prod[30:0]));
        end
        if (sat13_next)
        begin
            res13_next = neg12_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            res13_next = neg12_reg ? -$signed(prod[31:0]) : $signed(prod[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            scale_reg <= SCALE_RESET;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], start && !busy};
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mean1_reg  <= mean_value;
        noise1_reg <= noise_value;
        lv1_reg    <= lv1_next;

        mean2_reg  <= mean1_reg;
        noise2_reg <= noise1_reg;
        lvp2_reg   <= lvp2_next;

        mean3_reg  <= mean2_reg;
        noise3_reg <= noise2_reg;
        n3_reg     <= y[LV_W-1:FRAC_BITS];
        rem3_reg   <= f32[REM_W-1:0];
        e0_3_reg   <= EXP_ROM[ra0];
        e1_3_reg   <= EXP_ROM[ra1];

        mean4_reg  <= mean3_reg;
        noise4_reg <= noise3_reg;
        n4_reg     <= n3_reg;
        e0_4_reg   <= e0_3_reg;
        dp4_reg    <= dp4_next;

        mean5_reg  <= mean4_reg;
        noise5_reg <= noise4_reg;
        n5_reg     <= n4_reg;
        m5_reg     <= m5_next;

        mean6_reg  <= mean5_reg;
        n6_reg     <= n5_reg;
        mn6_reg    <= mn6_next;

        mean7_reg  <= mean6_reg;
        sh7_reg    <= sh7_next;
        neg7_reg   <= mn6_reg[63];
        mag7_reg   <= mag7_next;

        mean8_reg  <= mean7_reg;
        neg8_reg   <= neg7_reg;
        shf8_reg   <= shf8_next;

        sum9_reg   <= sum9_next;

        neg10_reg  <= sum9_reg[SUM_W-1];
        smag10_reg <= smag10_next;

        neg11_reg  <= neg10_reg;
        pl11_reg   <= pl11_next;
        ph11_reg   <= ph11_next;

        neg12_reg  <= neg11_reg;
        full12_reg <= full12_next;

        res13_reg  <= res13_next;
        sat13_reg  <= sat13_next;
    end

    assign done          = vld_reg[PIPE_LAT-1];
    assign latent_sample = res13_reg;
    assign saturated     = sat13_reg;

endmodule

/* src/gls_checker.sv */
// gls_checker: port-level checks of the gaussian latent sampler, with its bind.
// Depends on gls_pkg and binds to gaussian_latent_sampler_unit.
module gls_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic signed [gls_pkg::DATA_W-1:0] latent_sample,
    input logic                              saturated
);
    import gls_pkg::*;

    localparam int CNT_W = $clog2(PIPE_LAT + 1);

    logic [CNT_W-1:0] warm_reg;
    logic             warm;

    // cycles since reset release, until the pipeline has filled once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else if (warm_reg != CNT_W'(PIPE_LAT))
        begin
            warm_reg <= warm_reg + CNT_W'(1);
        end
    end

    assign warm = (warm_reg == CNT_W'(PIPE_LAT));

    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        warm && $past(start && !busy, PIPE_LAT) |-> done)
        else $error("accepted item gave no result");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        warm && done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without an accepted item");

    a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
        !warm && done |-> warm_reg >= CNT_W'(PIPE_LAT) || $past(start && !busy, PIPE_LAT))
        else $error("result before the pipeline filled");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> latent_sample == 32'sh7FFFFFFF || latent_sample == 32'sh80000000)
        else $error("saturated result not at a range limit");

endmodule

bind gaussian_latent_sampler_unit gls_checker u_gls_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .latent_sample (latent_sample),
    .saturated     (saturated)
);
